[design/cld_pkg.sv]
package cld_pkg;

   localparam int FrameLen = 26;
   localparam int FillWidth = $clog2(FrameLen + 1);

   localparam logic [7:0] HdrFirst = 8'hC1;
   localparam logic [7:0] HdrSecond = 8'h0A;
   localparam logic [7:0] TypeCommand = 8'h0B;
   localparam logic [63:0] ErasePayload = 64'hEF00_00FF_FFFC_FFFF;
   localparam logic [15:0] CountMax = 16'hFFFF;

   localparam logic [1:0] KIND_GOOD = 2'd0;
   localparam logic [1:0] KIND_ERASE = 2'd1;
   localparam logic [1:0] KIND_ERROR = 2'd2;

   typedef logic [FillWidth-1:0] fill_type;

   typedef enum logic [2:0] {
      ST_RUN,
      ST_CHECK,
      ST_SKIP_A,
      ST_SKIP_B,
      ST_SCAN
   } state_type;

   typedef struct packed {
      logic accept;
      logic load_result;
      logic shift;
      logic count_drop;
      logic finish_scan;
   } cmd_type;

   typedef struct packed {
      logic last_slot;
      logic sum_ok;
      logic out_free;
      logic rem_zero;
      logic scan_hit;
   } status_type;

endpackage

[design/can_log_frame_deframer.sv]
// channel   direction  handshake             payload
// req       in         req_valid/req_stall   req_rx_byte
// rsp       out        rsp_valid/rsp_stall   rsp_kind .. rsp_dropped_count
//
// One request byte is taken per cycle while the frame fills.
// The byte that completes a 26-byte frame leads to a check step, which waits
// while the previous result is still stalled in the output register.
// A checksum failure shifts out the two header bytes, then one dropped byte
// at a time until the rescan finds a header or the buffer runs empty.
// Synchronous active-high reset empties the buffer and clears the drop count.
// A stalled result does not block requests until the next frame completes.
module can_log_frame_deframer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_kind,
   output logic [7:0]  rsp_port_type,
   output logic [15:0] rsp_year,
   output logic [7:0]  rsp_month,
   output logic [7:0]  rsp_day,
   output logic [7:0]  rsp_hour,
   output logic [7:0]  rsp_minute,
   output logic [7:0]  rsp_second,
   output logic [15:0] rsp_millis,
   output logic [31:0] rsp_can_id,
   output logic [63:0] rsp_can_payload,
   output logic [15:0] rsp_dropped_count
);
   import cld_pkg::*;

   cmd_type    cmd;
   status_type status;

   cld_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   cld_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .req_rx_byte       (req_rx_byte),
      .cmd               (cmd),
      .status            (status),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_kind          (rsp_kind),
      .rsp_port_type     (rsp_port_type),
      .rsp_year          (rsp_year),
      .rsp_month         (rsp_month),
      .rsp_day           (rsp_day),
      .rsp_hour          (rsp_hour),
      .rsp_minute        (rsp_minute),
      .rsp_second        (rsp_second),
      .rsp_millis        (rsp_millis),
      .rsp_can_id        (rsp_can_id),
      .rsp_can_payload   (rsp_can_payload),
      .rsp_dropped_count (rsp_dropped_count)
   );

endmodule

[design/cld_ctrl.sv]
module cld_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  cld_pkg::status_type status,
   output cld_pkg::cmd_type    cmd
);
   import cld_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_RUN;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_RUN: begin
            req_stall = 1'b0;
            cmd.accept = req_valid;
            if (req_valid && status.last_slot) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            // hold the finished frame until the output register frees up
            if (status.out_free) begin
               cmd.load_result = 1'b1;
               state_in = status.sum_ok ? ST_RUN : ST_SKIP_A;
            end
         end
         ST_SKIP_A: begin
            cmd.shift = 1'b1;
            state_in = ST_SKIP_B;
         end
         ST_SKIP_B: begin
            cmd.shift = 1'b1;
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (status.rem_zero) begin
               state_in = ST_RUN;
            end else if (status.scan_hit) begin
               cmd.finish_scan = 1'b1;
               state_in = ST_RUN;
            end else begin
               cmd.shift = 1'b1;
               cmd.count_drop = 1'b1;
            end
         end
         default: begin
            state_in = ST_RUN;
         end
      endcase
   end

   a_load_needs_room: assert property (@(posedge clock) disable iff (reset)
      cmd.load_result |-> status.out_free)
      else $error("result loaded while output register is occupied");

   a_no_accept_in_scan: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (!cmd.accept && req_stall))
      else $error("request taken during rescan");

endmodule

[design/cld_datapath.sv]
module cld_datapath (
   input  logic                clock,
   input  logic                reset,
   input  logic [7:0]          req_rx_byte,
   input  cld_pkg::cmd_type    cmd,
   output cld_pkg::status_type status,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [1:0]          rsp_kind,
   output logic [7:0]          rsp_port_type,
   output logic [15:0]         rsp_year,
   output logic [7:0]          rsp_month,
   output logic [7:0]          rsp_day,
   output logic [7:0]          rsp_hour,
   output logic [7:0]          rsp_minute,
   output logic [7:0]          rsp_second,
   output logic [15:0]         rsp_millis,
   output logic [31:0]         rsp_can_id,
   output logic [63:0]         rsp_can_payload,
   output logic [15:0]         rsp_dropped_count
);
   import cld_pkg::*;

   logic [7:0]  frame_ff [FrameLen];
   fill_type    fill_ff;
   fill_type    fill_in;
   logic [7:0]  sum_ff;
   logic [7:0]  sum_in;
   logic [15:0] cnt_ff;
   logic [15:0] cnt_in;
   logic        rsp_valid_ff;
   logic        rsp_valid_in;

   logic [1:0]  kind_ff;
   logic [7:0]  port_type_ff;
   logic [15:0] year_ff;
   logic [7:0]  month_ff;
   logic [7:0]  day_ff;
   logic [7:0]  hour_ff;
   logic [7:0]  minute_ff;
   logic [7:0]  second_ff;
   logic [15:0] millis_ff;
   logic [31:0] can_id_ff;
   logic [63:0] payload_ff;
   logic [15:0] dropped_ff;

   logic        wr_en;
   fill_type    wr_idx;
   logic [1:0]  drop_n;
   logic [16:0] cnt_sum;
   logic [63:0] payload;
   logic        is_erase;

   assign payload = {frame_ff[17], frame_ff[18], frame_ff[19], frame_ff[20],
                     frame_ff[21], frame_ff[22], frame_ff[23], frame_ff[24]};
   assign is_erase = (frame_ff[2] == TypeCommand) && (payload == ErasePayload);

   assign status.last_slot = (fill_ff == fill_type'(FrameLen - 1));
   assign status.sum_ok = (sum_ff == frame_ff[FrameLen-1]);
   assign status.out_free = !rsp_valid_ff || !rsp_stall;
   assign status.rem_zero = (fill_ff == '0);
   assign status.scan_hit = (frame_ff[0] == HdrFirst) &&
                            ((fill_ff == fill_type'(1)) || (frame_ff[1] == HdrSecond));

   // byte placement while hunting for the header and filling the frame
   always_comb begin
      wr_en = 1'b1;
      wr_idx = fill_ff;
      if (fill_ff == '0) begin
         wr_en = (req_rx_byte == HdrFirst);
      end else if (fill_ff == fill_type'(1)) begin
         if (req_rx_byte == HdrSecond) begin
            wr_idx = fill_type'(1);
         end else begin
            wr_en = (req_rx_byte == HdrFirst);
            wr_idx = '0;
         end
      end
   end

   always_comb begin
      fill_in = fill_ff;
      sum_in = sum_ff;
      drop_n = 2'd0;
      if (cmd.accept) begin
         if (fill_ff == '0) begin
            if (req_rx_byte == HdrFirst) begin
               fill_in = fill_type'(1);
               sum_in = 8'd0;
            end else begin
               drop_n = 2'd1;
            end
         end else if (fill_ff == fill_type'(1)) begin
            if (req_rx_byte == HdrSecond) begin
               fill_in = fill_type'(2);
               sum_in = req_rx_byte;
            end else if (req_rx_byte == HdrFirst) begin
               drop_n = 2'd1;
            end else begin
               drop_n = 2'd2;
               fill_in = '0;
            end
         end else begin
            fill_in = fill_ff + fill_type'(1);
            // the checksum byte itself stays out of the sum
            if (fill_ff < fill_type'(FrameLen - 1)) begin
               sum_in = sum_ff + req_rx_byte;
            end
         end
      end
      if (cmd.load_result) begin
         if (status.sum_ok) begin
            fill_in = '0;
         end else begin
            // total over the whole frame; each shift removes the head byte
            sum_in = sum_ff + frame_ff[FrameLen-1] + frame_ff[0];
         end
      end
      if (cmd.shift) begin
         fill_in = fill_ff - fill_type'(1);
         sum_in = sum_ff - frame_ff[0];
         if (cmd.count_drop) begin
            drop_n = 2'd1;
         end
      end
      if (cmd.finish_scan) begin
         sum_in = sum_ff - frame_ff[0];
      end
   end

   assign cnt_sum = {1'b0, cnt_ff} + {15'd0, drop_n};
   assign cnt_in = cmd.load_result ? 16'd0 :
                   (cnt_sum[16] ? CountMax : cnt_sum[15:0]);
   assign rsp_valid_in = cmd.load_result || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         sum_ff <= '0;
         cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fill_ff <= fill_in;
         sum_ff <= sum_in;
         cnt_ff <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept && wr_en) begin
         frame_ff[wr_idx] <= req_rx_byte;
      end else if (cmd.shift) begin
         for (int i = 0; i < FrameLen - 1; i++) begin
            frame_ff[i] <= frame_ff[i+1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_result) begin
         dropped_ff <= cnt_ff;
         if (status.sum_ok) begin
            kind_ff <= is_erase ? KIND_ERASE : KIND_GOOD;
            port_type_ff <= frame_ff[2];
            year_ff <= {frame_ff[4], frame_ff[3]};
            month_ff <= frame_ff[5];
            day_ff <= frame_ff[6];
            hour_ff <= frame_ff[7];
            minute_ff <= frame_ff[8];
            second_ff <= frame_ff[9];
            millis_ff <= {frame_ff[11], frame_ff[10]};
            can_id_ff <= {frame_ff[16], frame_ff[15], frame_ff[14], frame_ff[13]};
            payload_ff <= payload;
         end else begin
            kind_ff <= KIND_ERROR;
            port_type_ff <= '0;
            year_ff <= '0;
            month_ff <= '0;
            day_ff <= '0;
            hour_ff <= '0;
            minute_ff <= '0;
            second_ff <= '0;
            millis_ff <= '0;
            can_id_ff <= '0;
            payload_ff <= '0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_kind = kind_ff;
   assign rsp_port_type = port_type_ff;
   assign rsp_year = year_ff;
   assign rsp_month = month_ff;
   assign rsp_day = day_ff;
   assign rsp_hour = hour_ff;
   assign rsp_minute = minute_ff;
   assign rsp_second = second_ff;
   assign rsp_millis = millis_ff;
   assign rsp_can_id = can_id_ff;
   assign rsp_can_payload = payload_ff;
   assign rsp_dropped_count = dropped_ff;

   a_fill_range: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= fill_type'(FrameLen))
      else $error("fill count beyond frame length");

   a_good_empties: assert property (@(posedge clock) disable iff (reset)
      (cmd.load_result && status.sum_ok) |=> (fill_ff == '0))
      else $error("buffer not emptied after good frame");

   a_shift_nonempty: assert property (@(posedge clock) disable iff (reset)
      cmd.shift |-> (fill_ff != '0))
      else $error("shift of an empty buffer");

endmodule

[sim/can_log_frame_deframer_checker.sv]
`timescale 1ns / 1ps

module can_log_frame_deframer_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [1:0]  rsp_kind,
   input  logic [7:0]  rsp_port_type,
   input  logic [15:0] rsp_year,
   input  logic [7:0]  rsp_month,
   input  logic [7:0]  rsp_day,
   input  logic [7:0]  rsp_hour,
   input  logic [7:0]  rsp_minute,
   input  logic [7:0]  rsp_second,
   input  logic [15:0] rsp_millis,
   input  logic [31:0] rsp_can_id,
   input  logic [63:0] rsp_can_payload,
   input  logic [15:0] rsp_dropped_count,
   output int          fail_count,
   output int          pending,
   output int          good_frames,
   output int          erase_frames,
   output int          error_frames
);
   import cld_pkg::*;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  port_type;
      logic [15:0] year;
      logic [7:0]  month;
      logic [7:0]  day;
      logic [7:0]  hour;
      logic [7:0]  minute;
      logic [7:0]  second;
      logic [15:0] millis;
      logic [31:0] can_id;
      logic [63:0] can_payload;
      logic [15:0] dropped;
   } deframed_type;

   logic [7:0] rx_frame [FrameLen];
   int         fill_level;
   logic [15:0] drop_tally;
   deframed_type expected_frames [$];

   task automatic add_drop(input int n);
      int t;
      t = int'(drop_tally) + n;
      drop_tally = (t > int'(CountMax)) ? CountMax : t[15:0];
   endtask

   task automatic take_byte(input logic [7:0] b);
      int i;
      int p;
      int sum;
      logic [63:0] payload;
      deframed_type r;
      if (fill_level == 0) begin
         if (b == HdrFirst) begin
            rx_frame[0] = b;
            fill_level = 1;
         end else begin
            add_drop(1);
         end
      end else if (fill_level == 1) begin
         if (b == HdrSecond) begin
            rx_frame[1] = b;
            fill_level = 2;
         end else if (b == HdrFirst) begin
            // drop the old lead byte, the new one starts the header again
            add_drop(1);
         end else begin
            add_drop(2);
            fill_level = 0;
         end
      end else begin
         rx_frame[fill_level] = b;
         fill_level++;
         if (fill_level == FrameLen) begin
            sum = 0;
            for (i = 1; i < FrameLen - 1; i++)
               sum += rx_frame[i];
            r = '0;
            r.dropped = drop_tally;
            drop_tally = '0;
            if (sum[7:0] == rx_frame[FrameLen - 1]) begin
               payload = '0;
               for (i = 17; i < FrameLen - 1; i++)
                  payload = {payload[55:0], rx_frame[i]};
               r.kind = (rx_frame[2] == TypeCommand && payload == ErasePayload) ?
                        KIND_ERASE : KIND_GOOD;
               r.port_type = rx_frame[2];
               r.year = {rx_frame[4], rx_frame[3]};
               r.month = rx_frame[5];
               r.day = rx_frame[6];
               r.hour = rx_frame[7];
               r.minute = rx_frame[8];
               r.second = rx_frame[9];
               r.millis = {rx_frame[11], rx_frame[10]};
               r.can_id = {rx_frame[16], rx_frame[15], rx_frame[14], rx_frame[13]};
               r.can_payload = payload;
               fill_level = 0;
               if (r.kind == KIND_ERASE)
                  erase_frames++;
               else
                  good_frames++;
            end else begin
               r.kind = KIND_ERROR;
               // rescan for the first aligned header; a lone lead byte at the end stays
               p = 2;
               while (p < FrameLen && !(rx_frame[p] == HdrFirst &&
                      (p == FrameLen - 1 || rx_frame[p + 1] == HdrSecond)))
                  p++;
               add_drop(p - 2);
               for (i = 0; i < FrameLen - p; i++)
                  rx_frame[i] = rx_frame[i + p];
               fill_level = FrameLen - p;
               error_frames++;
            end
            expected_frames.insert(expected_frames.size(), r);
         end
      end
   endtask

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (want !== got) begin
         fail_count++;
         if (fail_count <= 10)
            $display("%0t: rsp_%s mismatch: expected %h, actual %h", $time, name, want, got);
      end
   endtask

   task automatic check_result();
      deframed_type want;
      if (expected_frames.size() == 0) begin
         fail_count++;
         if (fail_count <= 10)
            $display("%0t: result with no request behind it, rsp_kind %0d", $time, rsp_kind);
      end else begin
         want = expected_frames.pop_front();
         check_field("kind", 64'(want.kind), 64'(rsp_kind));
         check_field("port_type", 64'(want.port_type), 64'(rsp_port_type));
         check_field("year", 64'(want.year), 64'(rsp_year));
         check_field("month", 64'(want.month), 64'(rsp_month));
         check_field("day", 64'(want.day), 64'(rsp_day));
         check_field("hour", 64'(want.hour), 64'(rsp_hour));
         check_field("minute", 64'(want.minute), 64'(rsp_minute));
         check_field("second", 64'(want.second), 64'(rsp_second));
         check_field("millis", 64'(want.millis), 64'(rsp_millis));
         check_field("can_id", 64'(want.can_id), 64'(rsp_can_id));
         check_field("can_payload", want.can_payload, rsp_can_payload);
         check_field("dropped_count", 64'(want.dropped), 64'(rsp_dropped_count));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         fill_level = 0;
         drop_tally = '0;
         expected_frames.delete();
         fail_count = 0;
         pending = 0;
         good_frames = 0;
         erase_frames = 0;
         error_frames = 0;
      end else begin
         // the result leaving now is older than any request taken now
         if (rsp_valid && !rsp_stall)
            check_result();
         if (req_valid && !req_stall)
            take_byte(req_rx_byte);
         pending = expected_frames.size();
      end
   end

endmodule

[sim/tb_can_log_frame_deframer.sv]
`timescale 1ns / 1ps

module tb_can_log_frame_deframer;
   import cld_pkg::*;

   localparam int QuietLimit = 1000;
   localparam int SettleCycles = 64;
   localparam int RandomBytes = 850;
   localparam int FloodBytes = 100;
   localparam int FrameOuter = 0;
   localparam int FrameInner = 1;

   typedef enum int {
      FILL_RANDOM,
      FILL_ZERO,
      FILL_ONES,
      FILL_ERASE,
      FILL_CMD_OTHER,
      FILL_ERASE_DATA
   } fill_style_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [7:0]  req_rx_byte;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [1:0]  rsp_kind;
   logic [7:0]  rsp_port_type;
   logic [15:0] rsp_year;
   logic [7:0]  rsp_month;
   logic [7:0]  rsp_day;
   logic [7:0]  rsp_hour;
   logic [7:0]  rsp_minute;
   logic [7:0]  rsp_second;
   logic [15:0] rsp_millis;
   logic [31:0] rsp_can_id;
   logic [63:0] rsp_can_payload;
   logic [15:0] rsp_dropped_count;

   int fail_count;
   int pending;
   int good_frames;
   int erase_frames;
   int error_frames;
   int pace_mode;
   int bytes_sent;
   int quiet_cycles;
   logic [7:0] frames [2][FrameLen];

   can_log_frame_deframer u_top (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_rx_byte(req_rx_byte),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_kind(rsp_kind),
      .rsp_port_type(rsp_port_type),
      .rsp_year(rsp_year),
      .rsp_month(rsp_month),
      .rsp_day(rsp_day),
      .rsp_hour(rsp_hour),
      .rsp_minute(rsp_minute),
      .rsp_second(rsp_second),
      .rsp_millis(rsp_millis),
      .rsp_can_id(rsp_can_id),
      .rsp_can_payload(rsp_can_payload),
      .rsp_dropped_count(rsp_dropped_count)
   );

   can_log_frame_deframer_checker u_checker (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_rx_byte(req_rx_byte),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_kind(rsp_kind),
      .rsp_port_type(rsp_port_type),
      .rsp_year(rsp_year),
      .rsp_month(rsp_month),
      .rsp_day(rsp_day),
      .rsp_hour(rsp_hour),
      .rsp_minute(rsp_minute),
      .rsp_second(rsp_second),
      .rsp_millis(rsp_millis),
      .rsp_can_id(rsp_can_id),
      .rsp_can_payload(rsp_can_payload),
      .rsp_dropped_count(rsp_dropped_count),
      .fail_count(fail_count),
      .pending(pending),
      .good_frames(good_frames),
      .erase_frames(erase_frames),
      .error_frames(error_frames)
   );

   always #4 clock = ~clock;

   function automatic int draw_wait();
      if (pace_mode == 0)
         return 0;
      if (pace_mode == 1)
         return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : 0;
      return $urandom_range(0, 8);
   endfunction

   function automatic logic [7:0] frame_sum(input int f);
      logic [7:0] s;
      int i;
      s = '0;
      for (i = 1; i < FrameLen - 1; i++)
         s += frames[f][i];
      return s;
   endfunction

   function automatic logic [7:0] noise_byte();
      logic [7:0] b;
      b = 8'($urandom_range(0, 255));
      if (b == HdrFirst)
         b = ~b;
      return b;
   endfunction

   task automatic send_byte(input logic [7:0] b);
      int gap;
      gap = draw_wait();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      bytes_sent++;
   endtask

   task automatic make_frame(input int f, input fill_style_type style);
      int i;
      frames[f][0] = HdrFirst;
      frames[f][1] = HdrSecond;
      for (i = 2; i < FrameLen - 1; i++) begin
         case (style)
            FILL_ZERO: frames[f][i] = 8'h00;
            FILL_ONES: frames[f][i] = 8'hFF;
            default: frames[f][i] = 8'($urandom_range(0, 255));
         endcase
      end
      if (style == FILL_ERASE || style == FILL_CMD_OTHER)
         frames[f][2] = TypeCommand;
      if (style == FILL_ERASE || style == FILL_ERASE_DATA) begin
         for (i = 0; i < 8; i++)
            frames[f][17 + i] = ErasePayload[63 - 8 * i -: 8];
      end
      if (style == FILL_ERASE_DATA && frames[f][2] == TypeCommand)
         frames[f][2] = TypeCommand + 8'd1;
      frames[f][FrameLen - 1] = frame_sum(f);
   endtask

   task automatic send_frame(input int f, input int first);
      int i;
      for (i = first; i < FrameLen; i++)
         send_byte(frames[f][i]);
   endtask

   function automatic fill_style_type pick_style();
      case ($urandom_range(0, 9))
         0: return FILL_ERASE;
         1: return FILL_CMD_OTHER;
         2: return FILL_ERASE_DATA;
         default: return FILL_RANDOM;
      endcase
   endfunction

   // bad frame whose rescan finds a header at byte p; the frame behind it is then completed
   task automatic send_nested(input int p);
      int i;
      do begin
         make_frame(FrameInner, pick_style());
         if ($urandom_range(0, 3) == 0)
            frames[FrameInner][FrameLen - 1] += 8'($urandom_range(1, 255));
         frames[FrameOuter][0] = HdrFirst;
         frames[FrameOuter][1] = HdrSecond;
         for (i = 2; i < p; i++)
            frames[FrameOuter][i] = noise_byte();
         for (i = p; i < FrameLen; i++)
            frames[FrameOuter][i] = frames[FrameInner][i - p];
      end while (frame_sum(FrameOuter) == frames[FrameOuter][FrameLen - 1]);
      send_frame(FrameOuter, 0);
      send_frame(FrameInner, FrameLen - p);
   endtask

   initial begin
      int start_count;
      int i;
      logic [7:0] b;
      clock = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_rx_byte = '0;
      pace_mode = 0;
      bytes_sent = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // noise, broken headers and a repeated lead byte ahead of the first frame
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(HdrFirst);
      send_byte(8'h00);
      send_byte(HdrFirst);
      send_byte(HdrFirst);
      make_frame(FrameOuter, FILL_ZERO);
      send_frame(FrameOuter, 0);
      make_frame(FrameOuter, FILL_ONES);
      send_frame(FrameOuter, 0);
      make_frame(FrameOuter, FILL_ERASE);
      send_frame(FrameOuter, 0);
      make_frame(FrameOuter, FILL_CMD_OTHER);
      send_frame(FrameOuter, 0);
      make_frame(FrameOuter, FILL_ERASE_DATA);
      send_frame(FrameOuter, 0);
      // bad checksum with no header inside: buffer empties
      make_frame(FrameOuter, FILL_ZERO);
      frames[FrameOuter][FrameLen - 1] += 8'h01;
      send_frame(FrameOuter, 0);
      send_nested(2);
      send_nested(13);
      send_nested(FrameLen - 1);

      // long noise run, then hand the drop count over with a good frame
      for (i = 0; i < FloodBytes; i++)
         send_byte(noise_byte());
      make_frame(FrameOuter, FILL_RANDOM);
      send_frame(FrameOuter, 0);

      start_count = bytes_sent;
      while (bytes_sent - start_count < RandomBytes) begin
         pace_mode = $urandom_range(0, 2);
         case ($urandom_range(0, 19))
            12, 13, 14: send_nested($urandom_range(2, FrameLen - 1));
            15, 16: begin
               send_byte(HdrFirst);
               b = 8'($urandom_range(0, 255));
               if (b == HdrSecond)
                  b = HdrFirst;
               send_byte(b);
            end
            17: begin
               // truncated frame overrun by whatever comes next
               send_byte(HdrFirst);
               send_byte(HdrSecond);
               repeat ($urandom_range(0, 20)) send_byte(8'($urandom_range(0, 255)));
            end
            18, 19: begin
               repeat ($urandom_range(1, 8)) begin
                  b = ($urandom_range(0, 3) == 0) ? HdrFirst : 8'($urandom_range(0, 255));
                  send_byte(b);
               end
            end
            default: begin
               make_frame(FrameOuter, pick_style());
               if ($urandom_range(0, 7) == 0)
                  frames[FrameOuter][FrameLen - 1] += 8'($urandom_range(1, 255));
               send_frame(FrameOuter, 0);
            end
         endcase
      end
      req_valid <= 1'b0;

      wait (pending == 0);
      repeat (SettleCycles) @(posedge clock);
      $display("Sent %0d request bytes, %0d of them in one run of noise.",
               bytes_sent, FloodBytes);
      $display("Checked %0d good, %0d erase-command and %0d checksum-error results.",
               good_frames, erase_frames, error_frames);
      if (fail_count == 0)
         $display("tb_can_log_frame_deframer passed");
      else
         $display("tb_can_log_frame_deframer failed");
      $finish;
   end

   // result side: stall for a drawn number of cycles, then take one result
   initial begin
      int hold;
      rsp_stall = 1'b0;
      while (reset) @(negedge clock);
      forever begin
         hold = draw_wait();
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
         @(negedge clock);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles == QuietLimit) begin
            $display("No request or result moved for %0d cycles", QuietLimit);
            $display("tb_can_log_frame_deframer failed");
            $finish;
         end
      end
   end

endmodule
